### sv/fssi_pkg.sv
// ----------------------------------------------------------------------------
// fssi_pkg: shared types and constants
// Types, widths and codes for the snapshot interpolator.
// ----------------------------------------------------------------------------
package fssi_pkg;

   localparam int PeriodW = 20;
   localparam int AlphaW  = 17;
   localparam int JumpW   = 31;
   localparam int PosW    = 32;
   localparam int HeadW   = 8;
   localparam int AccW    = 21;
   localparam int QuotW   = 17;
   localparam int CsrIdxW = 2;
   localparam int CsrDatW = 31;

   localparam logic [AlphaW-1:0] AlphaOne = 17'd65536;

   typedef enum logic [1:0] {
      KIND_FRAME   = 2'd0,
      KIND_CAPTURE = 2'd1,
      KIND_DISPLAY = 2'd2,
      KIND_CLEAR   = 2'd3
   } kind_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_PERIOD = 2'd0,
      CSR_LEAD   = 2'd1,
      CSR_JUMP   = 2'd2
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_RD,
      ST_CAP,
      ST_DSP,
      ST_DSP2,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [19:0] frame_time;
      logic [5:0]  slot;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [7:0]  heading;
      logic        restart;
      logic        batch_end;
   } req_type;

   typedef struct packed {
      logic        logic_tick;
      logic [16:0] blend_alpha;
      logic        ok;
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic [7:0]  out_heading;
   } rsp_type;

   // Snapshot entry: x, y, z, heading.
   localparam int SnapW = 3*PosW + HeadW;

   // Start / busy status of the divider.
   typedef struct packed {
      logic start;
      logic busy;
   } div_ctl_type;

endpackage

### sv/fssi_stream_if.sv
// ----------------------------------------------------------------------------
// fssi_stream_if: valid/ready channel
// Carries one payload per transfer.
// ----------------------------------------------------------------------------
interface fssi_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### sv/fssi_ram.sv
// ----------------------------------------------------------------------------
// fssi_ram: generic RAM with one write port and one read port
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fssi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

### sv/fssi_divider.sv
// ----------------------------------------------------------------------------
// fssi_divider: restoring divider
// Computes min(65536, round(num*65536/p)) one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fssi_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fssi_pkg::AccW:0]       num,
   input  logic [fssi_pkg::PeriodW-1:0]  period,
   output fssi_pkg::div_ctl_type         ctl,
   output logic [fssi_pkg::AlphaW-1:0]   alpha
);
   // Dividend is num*65536 + p/2. Once num >= p the result is clamped. Below
   // that, the dividend shifted right by 17 is already smaller than p, so
   // only the low 17 dividend bits have to be shifted in, one per cycle, and
   // they form the 17-bit quotient (65536 itself can come out for large p).
   localparam int DvdW = fssi_pkg::AccW + 1 + 16;
   logic [DvdW-1:0] dvd;
   logic [fssi_pkg::QuotW-1:0] low_ff, low_in;
   logic [fssi_pkg::PeriodW:0] rem_ff, rem_in;
   logic [fssi_pkg::QuotW-1:0] quo_ff, quo_in;
   logic [4:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, sat_ff, sat_in;
   logic [fssi_pkg::PeriodW:0] trial;
   logic [fssi_pkg::PeriodW+1:0] diff;

   assign dvd = {num, 16'd0} + {{(DvdW-fssi_pkg::PeriodW+1){1'b0}},
                                period[fssi_pkg::PeriodW-1:1]};

   always_comb begin
      low_in  = low_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      sat_in  = sat_ff;
      trial   = {rem_ff[fssi_pkg::PeriodW-1:0], low_ff[fssi_pkg::QuotW-1]};
      diff    = {1'b0, trial} - {2'b00, period};
      if (start) begin
         sat_in  = num >= {2'b00, period};
         rem_in  = dvd[DvdW-1:fssi_pkg::QuotW];
         low_in  = dvd[fssi_pkg::QuotW-1:0];
         quo_in  = '0;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[fssi_pkg::PeriodW+1]) begin
            rem_in = diff[fssi_pkg::PeriodW:0];
            quo_in = {quo_ff[fssi_pkg::QuotW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[fssi_pkg::QuotW-2:0], 1'b0};
         end
         low_in = low_ff << 1;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(fssi_pkg::QuotW - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      low_ff <= low_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      sat_ff <= sat_in;
   end

   assign ctl   = '{start: start, busy: busy_ff};
   assign alpha = sat_ff ? fssi_pkg::AlphaOne : quo_ff;
endmodule

### sv/fixed_step_snapshot_interpolator.sv
// ----------------------------------------------------------------------------
// fixed_step_snapshot_interpolator: fixed-timestep gate and snapshot blender
// Frame items run the tick gate and a serial divider for the blend factor;
// capture and display items use per-slot snapshot RAMs, and display items
// use a shared multiplier that blends one axis at a time.
// ----------------------------------------------------------------------------
//   channel   direction  handshake     payload
//   req_ch    in         valid/ready   kind, frame_time, slot, pos, heading, flags
//   rsp_ch    out        valid/ready   logic_tick, blend_alpha, ok, out_*
//   csr_      in         write enable  index, data (31 bits)
//
// A frame item starts the divider, waits for the bit-serial divider, loads
// the blend factor and transfers the result. Capture items do a RAM read, a
// compare and write, and the result; display items do a RAM read, four
// multiplies through one shared multiplier, and the result.
// One item is in flight at a time; req_ch.ready is low until the result
// transfer completes, also while the result waits. Reset is synchronous
// and clears control state only; the snapshot RAMs hold junk until written.
module fixed_step_snapshot_interpolator #(
   parameter int SLOTS = 64
) (
   input  logic clock,
   input  logic reset,
   fssi_stream_if.sink   req_ch,
   fssi_stream_if.source rsp_ch,
   input  logic                          csr_we,
   input  logic [fssi_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [fssi_pkg::CsrDatW-1:0]  csr_data
);
   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   logic [19:0] period_ff;
   logic        lead_ff;
   logic [30:0] jump_ff;
   logic [20:0] acc_ff, acc_in;
   logic [16:0] alpha_ff, alpha_in;
   logic        valid_ff, valid_in, inb_ff, inb_in, bsnap_ff, bsnap_in;
   logic [CW-1:0] scount_ff, scount_in, bcount_ff, bcount_in;
   fssi_pkg::state_type st_ff, st_in;
   fssi_pkg::req_type   it_ff, it_in;
   fssi_pkg::rsp_type   rs_ff, rs_in;
   logic [1:0] ax_ff, ax_in;
   logic signed [48:0] prod_ff;

   // CSR writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= 20'd33333;
         lead_ff   <= 1'b0;
         jump_ff   <= 31'd1048576;
      end else if (csr_we) begin
         unique case (fssi_pkg::csr_idx_type'(csr_index))
            fssi_pkg::CSR_PERIOD: period_ff <= csr_data[19:0];
            fssi_pkg::CSR_LEAD:   lead_ff   <= csr_data[0];
            fssi_pkg::CSR_JUMP:   jump_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   wire [19:0] per = (period_ff == 20'd0) ? 20'd1 : period_ff;

   // Snapshot RAMs: prev and next entries.
   logic ram_we;
   logic [AW-1:0] ram_addr;
   logic [fssi_pkg::SnapW-1:0] prev_wd, next_wd, prev_rd, next_rd;
   fssi_ram #(.WIDTH(fssi_pkg::SnapW), .DEPTH(SLOTS)) u_prev (
      .clock, .wr_en(ram_we), .wr_addr(ram_addr), .wr_data(prev_wd),
      .rd_addr(ram_addr), .rd_data(prev_rd));
   fssi_ram #(.WIDTH(fssi_pkg::SnapW), .DEPTH(SLOTS)) u_next (
      .clock, .wr_en(ram_we), .wr_addr(ram_addr), .wr_data(next_wd),
      .rd_addr(ram_addr), .rd_data(next_rd));
   assign ram_addr = AW'(it_ff.slot);

   // Divider.
   logic div_start;
   logic [21:0] div_num;
   fssi_pkg::div_ctl_type div_ctl;
   logic [16:0] div_alpha;
   fssi_divider u_div (.clock, .reset, .start(div_start), .num(div_num),
      .period(per), .ctl(div_ctl), .alpha(div_alpha));
   assign div_num = {1'b0, acc_ff} + (lead_ff ? {2'b00, it_ff.frame_time} : 22'd0);

   // Shared blend multiplier: one signed axis difference times alpha.
   logic signed [32:0] dsel;
   logic signed [31:0] bsel;
   wire signed [32:0] px = $signed(prev_rd[103:72]), nx = $signed(next_rd[103:72]);
   wire signed [32:0] py = $signed(prev_rd[71:40]),  ny = $signed(next_rd[71:40]);
   wire signed [32:0] pz = $signed(prev_rd[39:8]),   nz = $signed(next_rd[39:8]);
   wire [7:0] hdiff = next_rd[7:0] - prev_rd[7:0] + 8'd128;
   always_comb begin
      case (ax_ff)
         2'd0: begin dsel = nx - px; bsel = prev_rd[103:72]; end
         2'd1: begin dsel = ny - py; bsel = prev_rd[71:40]; end
         2'd2: begin dsel = nz - pz; bsel = prev_rd[39:8]; end
         default: begin
            dsel = 33'($signed({1'b0, hdiff}) - 33'sd128);
            bsel = {24'd0, prev_rd[7:0]};
         end
      endcase
   end
   always_ff @(posedge clock) begin
      prod_ff <= 49'(dsel * $signed({1'b0, alpha_ff}));
   end
   // Round half away from zero, then add prev.
   logic [48:0] mag;
   logic [32:0] rq;
   logic [31:0] blended;
   logic signed [31:0] bprev_ff;
   always_comb begin
      mag = prod_ff[48] ? 49'(-prod_ff) : prod_ff;
      mag = mag + 49'd32768;
      rq  = prod_ff[48] ? 33'(-$signed({1'b0, mag[48:16]})) : mag[48:16];
      blended = bprev_ff + rq[31:0];
   end
   always_ff @(posedge clock) bprev_ff <= bsel;

   function automatic logic far(input logic [31:0] o, input logic [31:0] n,
                                input logic [30:0] lim);
      logic signed [32:0] d;
      d = $signed({n[31], n}) - $signed({o[31], o});
      return (d > $signed({2'b00, lim})) || (d < -$signed({2'b00, lim}));
   endfunction

   logic in_rng;
   assign in_rng = {3'b000, it_ff.slot} < 9'(SLOTS);

   always_comb begin
      logic snap;
      logic [20:0] a2;
      st_in = st_ff; it_in = it_ff; rs_in = rs_ff; ax_in = ax_ff;
      acc_in = acc_ff; alpha_in = alpha_ff; valid_in = valid_ff;
      inb_in = inb_ff; bsnap_in = bsnap_ff; scount_in = scount_ff;
      bcount_in = bcount_ff; ram_we = 1'b0; div_start = 1'b0;
      prev_wd = '0; next_wd = '0; snap = 1'b0; a2 = '0;
      req_ch.ready = (st_ff == fssi_pkg::ST_IDLE);
      unique case (st_ff)
         fssi_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               it_in = req_ch.payload;
               rs_in = '0;
               unique case (fssi_pkg::kind_type'(req_ch.payload.kind))
                  fssi_pkg::KIND_FRAME: begin
                     a2 = acc_ff + {1'b0, req_ch.payload.frame_time};
                     if (a2 >= {1'b0, per}) begin
                        rs_in.logic_tick = 1'b1;
                        a2 = a2 - {1'b0, per};
                        if (a2 > {1'b0, per}) a2 = {1'b0, per};
                     end
                     acc_in = a2;
                     // Frame items do not use restart; it marks that the
                     // divider has been started.
                     it_in.restart = 1'b0;
                     st_in = fssi_pkg::ST_DIV;
                  end
                  fssi_pkg::KIND_CAPTURE: begin
                     if (!inb_ff) begin
                        inb_in = 1'b1; bcount_in = '0;
                        bsnap_in = req_ch.payload.restart || !valid_ff;
                        if (req_ch.payload.restart) valid_in = 1'b0;
                     end
                     st_in = fssi_pkg::ST_RD;
                  end
                  fssi_pkg::KIND_DISPLAY: begin
                     st_in = fssi_pkg::ST_RD;
                  end
                  fssi_pkg::KIND_CLEAR: begin
                     acc_in = '0; valid_in = 1'b0; scount_in = '0;
                     inb_in = 1'b0; bsnap_in = 1'b0; bcount_in = '0;
                     st_in = fssi_pkg::ST_OUT;
                  end
               endcase
            end
         end
         fssi_pkg::ST_DIV: begin
            if (!div_ctl.busy && !it_ff.restart) begin
               div_start = 1'b1;
               it_in.restart = 1'b1;
            end else if (!div_ctl.busy && !div_ctl.start) begin
               alpha_in = div_alpha;
               st_in = fssi_pkg::ST_OUT;
            end
         end
         fssi_pkg::ST_RD: begin
            st_in = (it_ff.kind == fssi_pkg::KIND_CAPTURE) ? fssi_pkg::ST_CAP
                                                           : fssi_pkg::ST_DSP;
            ax_in = 2'd0;
         end
         fssi_pkg::ST_CAP: begin
            if (in_rng) begin
               snap = bsnap_ff || ({3'b000, it_ff.slot} >= 9'(scount_ff)) ||
                      far(next_rd[103:72], it_ff.pos_x, jump_ff) ||
                      far(next_rd[71:40],  it_ff.pos_y, jump_ff) ||
                      far(next_rd[39:8],   it_ff.pos_z, jump_ff);
               next_wd = {it_ff.pos_x, it_ff.pos_y, it_ff.pos_z, it_ff.heading};
               prev_wd = snap ? next_wd : next_rd;
               ram_we = 1'b1;
               if (bcount_ff < CW'(SLOTS)) bcount_in = bcount_ff + 1'b1;
            end
            if (it_ff.batch_end) begin
               scount_in = in_rng && bcount_ff < CW'(SLOTS) ? bcount_ff + 1'b1
                                                             : bcount_ff;
               valid_in = scount_in != '0;
               inb_in = 1'b0;
            end
            st_in = fssi_pkg::ST_OUT;
         end
         fssi_pkg::ST_DSP: begin
            // Multiplier fed this cycle for axis ax_ff; result next cycle.
            st_in = fssi_pkg::ST_DSP2;
         end
         fssi_pkg::ST_DSP2: begin
            case (ax_ff)
               2'd0: rs_in.out_x = blended;
               2'd1: rs_in.out_y = blended;
               2'd2: rs_in.out_z = blended;
               default: rs_in.out_heading = blended[7:0];
            endcase
            ax_in = ax_ff + 2'd1;
            if (ax_ff == 2'd3) begin
               if (!(valid_ff && {3'b000, it_ff.slot} < 9'(scount_ff) && in_rng)) begin
                  rs_in = '0;
               end else begin
                  rs_in.ok = 1'b1;
               end
               st_in = fssi_pkg::ST_OUT;
            end else begin
               st_in = fssi_pkg::ST_DSP;
            end
         end
         fssi_pkg::ST_OUT: begin
            if (rsp_ch.ready) st_in = fssi_pkg::ST_IDLE;
         end
         default: st_in = fssi_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= fssi_pkg::ST_IDLE;
         acc_ff <= '0; alpha_ff <= fssi_pkg::AlphaOne; valid_ff <= 1'b0;
         inb_ff <= 1'b0; bsnap_ff <= 1'b0; scount_ff <= '0; bcount_ff <= '0;
      end else begin
         st_ff <= st_in;
         acc_ff <= acc_in; alpha_ff <= alpha_in; valid_ff <= valid_in;
         inb_ff <= inb_in; bsnap_ff <= bsnap_in; scount_ff <= scount_in;
         bcount_ff <= bcount_in;
      end
      it_ff <= it_in; rs_ff <= rs_in; ax_ff <= ax_in;
   end

   always_comb begin
      rsp_ch.valid = (st_ff == fssi_pkg::ST_OUT);
      rsp_ch.payload = rs_ff;
      rsp_ch.payload.blend_alpha = alpha_ff;
   end

   a_alpha_max: assert property (@(posedge clock) disable iff (reset)
      alpha_ff <= fssi_pkg::AlphaOne) else $error("alpha above one");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid && $stable(rsp_ch.payload))
      else $error("result changed while waiting");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready) else $error("ready during result");
endmodule
